@@ design/sled_pkg.sv @@
// Package: types, codes and helpers shared by the status LED pattern controller.
`default_nettype none
package sled_pkg;

  // Width of the millisecond countdown timer.
  localparam int TIMER_WIDTH = 16;
  // Width of the period configuration registers.
  localparam int PERIOD_W    = 16;

  localparam logic [PERIOD_W-1:0] RST_SLOW_ON   = PERIOD_W'(100);
  localparam logic [PERIOD_W-1:0] RST_SLOW_OFF  = PERIOD_W'(1800);
  localparam logic [PERIOD_W-1:0] RST_FAST_HALF = PERIOD_W'(100);
  localparam logic [PERIOD_W-1:0] RST_FLASH     = PERIOD_W'(10);
  localparam logic [PERIOD_W-1:0] RST_PULSE_OFF = PERIOD_W'(50);
  localparam logic [PERIOD_W-1:0] RST_PULSE_ON  = PERIOD_W'(200);
  localparam logic [PERIOD_W-1:0] RST_SETTLE    = PERIOD_W'(10);

  typedef enum logic [2:0] {
    MODE_OFF   = 3'd0,
    MODE_ON    = 3'd1,
    MODE_SLOW  = 3'd2,
    MODE_FAST  = 3'd3,
    MODE_FLASH = 3'd4,
    MODE_PULSE = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    FUNC_TICK     = 3'd0,
    FUNC_SET      = 3'd1,
    FUNC_OVERRIDE = 3'd2,
    FUNC_REVERT   = 3'd3,
    FUNC_READ     = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    CFG_INVERT    = 3'd0,
    CFG_SLOW_ON   = 3'd1,
    CFG_SLOW_OFF  = 3'd2,
    CFG_FAST_HALF = 3'd3,
    CFG_FLASH     = 3'd4,
    CFG_PULSE_OFF = 3'd5,
    CFG_PULSE_ON  = 3'd6,
    CFG_SETTLE    = 3'd7
  } cfg_idx_t;

  // One result beat.
  typedef struct packed {
    logic  pin_drive;
    logic  drive_enable;
    logic  read_done;
    logic  read_level;
    mode_t active_mode;
  } res_t;

  // Maps a raw mode code onto a legal mode; unused codes mean off.
  function automatic mode_t fix_mode(logic [2:0] m);
    mode_t r;
    r = MODE_OFF;
    if (m <= 3'd5) begin
      r = mode_t'(m);
    end
    return r;
  endfunction

  // Loads a period into the timer, saturating when it does not fit.
  function automatic logic [TIMER_WIDTH-1:0] sat_period(logic [PERIOD_W-1:0] p);
    logic [TIMER_WIDTH-1:0] r;
    if ((p >> TIMER_WIDTH) != '0) begin
      r = '1;
    end else begin
      r = TIMER_WIDTH'(p);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/status_led_pattern_controller.sv @@
// Top level: status LED pattern engine with a two-entry result buffer.
`default_nettype none
// Each input beat (millisecond tick, mode set, override, revert or pin read
// request) is accepted at a clock edge: the pattern state, the countdown timer
// and the read sequencer are updated at the accepting edge, and the result
// beat is written into the output buffer at that same edge, so the block
// sustains one beat per clock while in_stall is low. The output side has a
// second, skid register; in_stall rises only while that skid entry holds a
// result, which happens only after the consumer has stalled with the output
// register already full. Results therefore appear on out_* in the cycle after
// their input beat when the consumer keeps up. Periods count in input ticks,
// not clock cycles: the countdown is loaded when an event runs a pattern step
// and decremented by each tick beat. A read request releases the pin
// (drive_enable low), waits settle_r ticks, then samples in_pin_sample,
// reports it with the polarity correction on read_done/read_level and
// advances the pattern one step. Configuration writes on cfg_* take effect
// at once and should only be made while no beat is in flight.
module status_led_pattern_controller
  import sled_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Configuration write port.
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [PERIOD_W-1:0] cfg_wdata,
  // Input channel.
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_func,
  input  wire logic [2:0]          in_mode_req,
  input  wire logic                in_pin_sample,
  // Result channel.
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_pin_drive,
  output logic                     out_drive_enable,
  output logic                     out_read_done,
  output logic                     out_read_level,
  output logic [2:0]               out_active_mode
);

  // Configuration registers.
  logic                invert_r;
  logic [PERIOD_W-1:0] slow_on_r, slow_off_r, fast_half_r, flash_r;
  logic [PERIOD_W-1:0] pulse_off_r, pulse_on_r, settle_r;

  // Pattern state.
  mode_t                  cur_mode_r, cur_mode_nxt;
  mode_t                  rem_mode_r, rem_mode_nxt;
  logic                   ovr_r, ovr_nxt;
  logic                   phase_r, phase_nxt;
  logic                   lit_r, lit_nxt;
  logic                   read_pend_r, read_pend_nxt;
  logic                   settle_pend_r, settle_pend_nxt;
  logic [TIMER_WIDTH-1:0] cd_r, cd_nxt;

  // Output buffer: main register and skid register.
  logic out_valid_r, skid_valid_r;
  res_t out_res_r, skid_res_r;
  res_t res_nxt;

  logic in_acc, out_take;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r    <= 1'b0;
      slow_on_r   <= RST_SLOW_ON;
      slow_off_r  <= RST_SLOW_OFF;
      fast_half_r <= RST_FAST_HALF;
      flash_r     <= RST_FLASH;
      pulse_off_r <= RST_PULSE_OFF;
      pulse_on_r  <= RST_PULSE_ON;
      settle_r    <= RST_SETTLE;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INVERT:    invert_r    <= cfg_wdata[0];
        CFG_SLOW_ON:   slow_on_r   <= cfg_wdata;
        CFG_SLOW_OFF:  slow_off_r  <= cfg_wdata;
        CFG_FAST_HALF: fast_half_r <= cfg_wdata;
        CFG_FLASH:     flash_r     <= cfg_wdata;
        CFG_PULSE_OFF: pulse_off_r <= cfg_wdata;
        CFG_PULSE_ON:  pulse_on_r  <= cfg_wdata;
        CFG_SETTLE:    settle_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next pattern state and the result for the beat on the input ports.
  always_comb begin
    mode_t               mreq;
    logic                run;
    logic                done;
    logic                level;
    logic [PERIOD_W-1:0] period;

    mreq            = fix_mode(in_mode_req);
    run             = 1'b0;
    done            = 1'b0;
    level           = 1'b0;
    period          = '0;
    cur_mode_nxt    = cur_mode_r;
    rem_mode_nxt    = rem_mode_r;
    ovr_nxt         = ovr_r;
    phase_nxt       = phase_r;
    lit_nxt         = lit_r;
    read_pend_nxt   = read_pend_r;
    settle_pend_nxt = settle_pend_r;
    cd_nxt          = cd_r;

    // Events run a step, but not overridden sets, spare codes or early ticks.
    case (in_func)
      FUNC_TICK: begin
        if (cd_r != '0) begin
          cd_nxt = cd_r - TIMER_WIDTH'(1);
          run    = (cd_r == TIMER_WIDTH'(1));
        end
      end
      FUNC_SET: begin
        rem_mode_nxt = mreq;
        if (!ovr_r) begin
          cur_mode_nxt = mreq;
          phase_nxt    = (mreq == MODE_ON);
          lit_nxt      = (mreq != MODE_OFF);
          run          = 1'b1;
        end
      end
      FUNC_OVERRIDE: begin
        ovr_nxt      = 1'b1;
        cur_mode_nxt = mreq;
        phase_nxt    = (mreq == MODE_ON);
        lit_nxt      = (mreq != MODE_OFF);
        run          = 1'b1;
      end
      FUNC_REVERT: begin
        ovr_nxt      = 1'b0;
        cur_mode_nxt = rem_mode_r;
        phase_nxt    = (rem_mode_r == MODE_ON);
        lit_nxt      = (rem_mode_r != MODE_OFF);
        run          = 1'b1;
      end
      FUNC_READ: begin
        lit_nxt         = 1'b0;
        read_pend_nxt   = 1'b1;
        settle_pend_nxt = 1'b1;
        run             = 1'b1;
      end
      default: ;
    endcase

    // One pattern step: either start the settle wait, or finish a read and
    // advance the display pattern.
    if (run) begin
      if (settle_pend_nxt) begin
        settle_pend_nxt = 1'b0;
        period          = settle_r;
      end else begin
        if (read_pend_nxt) begin
          done          = 1'b1;
          level         = in_pin_sample ^ invert_r;
          read_pend_nxt = 1'b0;
        end
        case (cur_mode_nxt)
          MODE_ON: begin
            phase_nxt = 1'b1;
            lit_nxt   = 1'b1;
          end
          MODE_SLOW: begin
            phase_nxt = !phase_nxt;
            lit_nxt   = phase_nxt;
            period    = phase_nxt ? slow_on_r : slow_off_r;
          end
          MODE_FAST: begin
            phase_nxt = !phase_nxt;
            lit_nxt   = phase_nxt;
            period    = fast_half_r;
          end
          MODE_FLASH: begin
            if (phase_nxt) begin
              lit_nxt = 1'b0;
            end else begin
              phase_nxt = 1'b1;
              period    = flash_r;
            end
          end
          MODE_PULSE: begin
            phase_nxt = !phase_nxt;
            lit_nxt   = phase_nxt;
            period    = phase_nxt ? pulse_on_r : pulse_off_r;
          end
          default: begin
            phase_nxt = 1'b0;
            lit_nxt   = 1'b0;
          end
        endcase
      end
      cd_nxt = sat_period(period);
    end

    res_nxt.pin_drive    = lit_nxt ^ invert_r;
    res_nxt.drive_enable = !read_pend_nxt;
    res_nxt.read_done    = done;
    res_nxt.read_level   = level;
    res_nxt.active_mode  = cur_mode_nxt;
  end

  // State commits only on an accepted input beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mode_r    <= MODE_OFF;
      rem_mode_r    <= MODE_OFF;
      ovr_r         <= 1'b0;
      phase_r       <= 1'b0;
      lit_r         <= 1'b0;
      read_pend_r   <= 1'b0;
      settle_pend_r <= 1'b0;
      cd_r          <= '0;
    end else if (in_acc) begin
      cur_mode_r    <= cur_mode_nxt;
      rem_mode_r    <= rem_mode_nxt;
      ovr_r         <= ovr_nxt;
      phase_r       <= phase_nxt;
      lit_r         <= lit_nxt;
      read_pend_r   <= read_pend_nxt;
      settle_pend_r <= settle_pend_nxt;
      cd_r          <= cd_nxt;
    end
  end

  // Result buffer. A new result goes to the output register when it is free
  // or being drained this cycle, and otherwise to the skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_res_r <= skid_res_r;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_res_r <= res_nxt;
      end else begin
        skid_res_r <= res_nxt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pin_drive    = out_res_r.pin_drive;
  assign out_drive_enable = out_res_r.drive_enable;
  assign out_read_done    = out_res_r.read_done;
  assign out_read_level   = out_res_r.read_level;
  assign out_active_mode  = out_res_r.active_mode;

endmodule
`default_nettype wire

@@ tb/status_led_pattern_controller_tb.sv @@
// Self-checking testbench for the status LED pattern controller.
`timescale 1ns / 1ps

module status_led_pattern_controller_tb;
  import sled_pkg::*;

  localparam int CLK_HIGH_NS    = 5;
  localparam int CLK_LOW_NS     = 5;
  localparam int RESET_CYCLES   = 8;
  // The worst honest quiet stretch is the long receiver hold-off below plus a
  // few random gaps, so this is several times what a correct run can reach.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  // Results are registered in the block's output buffer; a short tail catches strays.
  localparam int TAIL_CYCLES    = 10;

  localparam longint CNT_MAX = (64'd1 << TIMER_WIDTH) - 1;

  // Codes outside the legal ranges; the block must treat them as described.
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0] func;
    logic [2:0] mode;
    logic       sample;
  } led_cmd_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [PERIOD_W-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [2:0]          in_func = '0;
  logic [2:0]          in_mode_req = '0;
  logic                in_pin_sample = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_pin_drive;
  logic                out_drive_enable;
  logic                out_read_done;
  logic                out_read_level;
  logic [2:0]          out_active_mode;

  status_led_pattern_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_mode_req      (in_mode_req),
    .in_pin_sample    (in_pin_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pin_drive    (out_pin_drive),
    .out_drive_enable (out_drive_enable),
    .out_read_done    (out_read_done),
    .out_read_level   (out_read_level),
    .out_active_mode  (out_active_mode)
  );

  always begin
    #CLK_HIGH_NS clk = 1'b1;
    #CLK_LOW_NS  clk = 1'b0;
  end

  // Commands waiting to be offered, and the result beats still owed by the
  // block, oldest first.
  led_cmd_t pending_cmds[$];
  res_t     owed_results[$];

  // Traffic shaping, set by the sequencer between phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int  fail_count = 0;
  int  quiet_cycles = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;

  // Shadow of the LED engine. It mirrors the block's state beat by beat and
  // is advanced only from the monitor, at the edge where a beat is accepted.
  mode_t               led_mode;
  mode_t               led_saved_mode;
  bit                  led_override;
  bit                  led_phase;
  bit                  led_lit;
  bit                  led_read_pend;
  bit                  led_settle_pend;
  bit                  led_done;
  bit                  led_level;
  logic [TIMER_WIDTH-1:0] led_count;
  bit                  led_invert;
  logic [PERIOD_W-1:0] led_period [8];

  function automatic mode_t legal_mode(logic [2:0] m);
    return (m > MODE_PULSE) ? MODE_OFF : mode_t'(m);
  endfunction

  function automatic void enter_mode(mode_t m);
    led_mode  = m;
    led_phase = (m == MODE_ON);
    led_lit   = (m != MODE_OFF);
  endfunction

  // One step of the pattern: the settle wait of a read comes first, then the
  // read is completed, then the current mode moves on and picks its period.
  function automatic void pattern_advance(logic sample);
    logic [PERIOD_W-1:0] p;
    p = '0;
    if (led_settle_pend) begin
      led_settle_pend = 1'b0;
      p = led_period[CFG_SETTLE];
    end else begin
      if (led_read_pend) begin
        led_done      = 1'b1;
        led_level     = sample ^ led_invert;
        led_read_pend = 1'b0;
      end
      case (led_mode)
        MODE_ON: begin
          led_phase = 1'b1;
          led_lit   = 1'b1;
        end
        MODE_SLOW: begin
          led_phase = !led_phase;
          led_lit   = led_phase;
          p = led_phase ? led_period[CFG_SLOW_ON] : led_period[CFG_SLOW_OFF];
        end
        MODE_FAST: begin
          led_phase = !led_phase;
          led_lit   = led_phase;
          p = led_period[CFG_FAST_HALF];
        end
        MODE_FLASH: begin
          // A single flash goes dark for good once its lit time is over.
          if (led_phase) begin
            led_lit = 1'b0;
          end else begin
            led_phase = 1'b1;
            p = led_period[CFG_FLASH];
          end
        end
        MODE_PULSE: begin
          led_phase = !led_phase;
          led_lit   = led_phase;
          p = led_phase ? led_period[CFG_PULSE_ON] : led_period[CFG_PULSE_OFF];
        end
        default: begin
          led_phase = 1'b0;
          led_lit   = 1'b0;
        end
      endcase
    end
    // A period of zero leaves the timer idle; one too wide saturates.
    led_count = (longint'(p) > CNT_MAX) ? '1 : TIMER_WIDTH'(p);
  endfunction

  function automatic res_t predict_led(logic [2:0] func, logic [2:0] mode_raw,
                                       logic sample);
    res_t  r;
    mode_t m;
    m = legal_mode(mode_raw);
    led_done  = 1'b0;
    led_level = 1'b0;
    case (func)
      FUNC_TICK: begin
        if (led_count != '0) begin
          led_count = led_count - TIMER_WIDTH'(1);
          if (led_count == '0) begin
            pattern_advance(sample);
          end
        end
      end
      FUNC_SET: begin
        // Under an override the new mode is only remembered.
        led_saved_mode = m;
        if (!led_override) begin
          enter_mode(m);
          pattern_advance(sample);
        end
      end
      FUNC_OVERRIDE: begin
        led_override = 1'b1;
        enter_mode(m);
        pattern_advance(sample);
      end
      FUNC_REVERT: begin
        led_override = 1'b0;
        enter_mode(led_saved_mode);
        pattern_advance(sample);
      end
      FUNC_READ: begin
        // The LED goes dark and the pin is released; a repeated request
        // simply restarts the settle wait.
        led_lit         = 1'b0;
        led_read_pend   = 1'b1;
        led_settle_pend = 1'b1;
        pattern_advance(sample);
      end
      default: begin
      end
    endcase
    r.pin_drive    = led_lit ^ led_invert;
    r.drive_enable = !led_read_pend;
    r.read_done    = led_done;
    r.read_level   = led_level;
    r.active_mode  = led_mode;
    return r;
  endfunction

  task automatic check_field(string field, logic [2:0] want, logic [2:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // Monitor: samples both channels and the configuration port at the rising
  // edge. Result beats are checked before the beat accepted at the same edge
  // is predicted, so a stray result can never be matched against it.
  always @(posedge clk) begin
    in_taken  = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    if (!rst_n) begin
      led_mode        = MODE_OFF;
      led_saved_mode  = MODE_OFF;
      led_override    = 1'b0;
      led_phase       = 1'b0;
      led_lit         = 1'b0;
      led_read_pend   = 1'b0;
      led_settle_pend = 1'b0;
      led_count       = '0;
      led_invert      = 1'b0;
      led_period[CFG_INVERT]    = '0;
      led_period[CFG_SLOW_ON]   = RST_SLOW_ON;
      led_period[CFG_SLOW_OFF]  = RST_SLOW_OFF;
      led_period[CFG_FAST_HALF] = RST_FAST_HALF;
      led_period[CFG_FLASH]     = RST_FLASH;
      led_period[CFG_PULSE_OFF] = RST_PULSE_OFF;
      led_period[CFG_PULSE_ON]  = RST_PULSE_ON;
      led_period[CFG_SETTLE]    = RST_SETTLE;
    end else begin
      if (out_taken) begin
        if (owed_results.size() == 0) begin
          $error("result beat arrived with no expectation waiting");
          fail_count++;
        end else begin
          res_t want;
          want = owed_results.pop_front();
          check_field("pin_drive", 3'(want.pin_drive), 3'(out_pin_drive));
          check_field("drive_enable", 3'(want.drive_enable), 3'(out_drive_enable));
          check_field("read_done", 3'(want.read_done), 3'(out_read_done));
          check_field("read_level", 3'(want.read_level), 3'(out_read_level));
          check_field("active_mode", want.active_mode, out_active_mode);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_INVERT) begin
          led_invert = cfg_wdata[0];
        end else begin
          led_period[cfg_index] = cfg_wdata;
        end
      end
      if (in_taken) begin
        owed_results.push_back(predict_led(in_func, in_mode_req, in_pin_sample));
      end
    end
    // Watchdog: only cycles with work outstanding count as stuck.
    if (in_taken || out_taken) begin
      quiet_cycles = 0;
    end else if (pending_cmds.size() != 0 || owed_results.size() != 0 || in_valid) begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status_led_pattern_controller_tb failed");
      $finish;
    end
  end

  // Driver: changes the input beat at the falling edge. A beat that is being
  // offered stays put until it has been taken; only then may the next one be
  // offered or the channel go idle.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        led_cmd_t c;
        c = pending_cmds.pop_front();
        in_valid      <= 1'b1;
        in_func       <= c.func;
        in_mode_req   <= c.mode;
        in_pin_sample <= c.sample;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request that lets the
  // block fill its output buffer and push back on the input channel.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic queue_cmd(logic [2:0] func, logic [2:0] mode, logic sample);
    led_cmd_t c;
    c.func   = func;
    c.mode   = mode;
    c.sample = sample;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [2:0] random_mode();
    if ($urandom_range(0, 9) == 0) begin
      return 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    end
    return 3'($urandom_range(MODE_OFF, MODE_PULSE));
  endfunction

  function automatic logic [2:0] random_func();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 58) return FUNC_TICK;
    if (pick < 70) return FUNC_SET;
    if (pick < 78) return FUNC_OVERRIDE;
    if (pick < 86) return FUNC_REVERT;
    if (pick < 97) return FUNC_READ;
    return 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
  endfunction

  // Most of the traffic is shaped: a random event, a mode event or a read request
  // followed by a run of ticks, so that periods expire and reads settle and complete.
  // The rest is single random beats.
  task automatic queue_random(int count);
    int made;
    int kind;
    int run;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        if (kind < 3) begin
          queue_cmd(random_func(), random_mode(), 1'($urandom_range(0, 1)));
        end else if (kind < 5) begin
          queue_cmd(($urandom_range(0, 1) == 0) ? FUNC_SET : FUNC_OVERRIDE,
                    random_mode(), 1'($urandom_range(0, 1)));
        end else begin
          queue_cmd(FUNC_READ, random_mode(), 1'($urandom_range(0, 1)));
        end
        made++;
        run = $urandom_range(1, 12);
        while (run > 0 && made < count) begin
          queue_cmd(FUNC_TICK, random_mode(), 1'($urandom_range(0, 1)));
          made++;
          run--;
        end
      end else begin
        queue_cmd(random_func(), random_mode(), 1'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  // Waits until every command has been taken and every result checked.
  task automatic wait_drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_cmds.size() != 0 || in_valid || owed_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [PERIOD_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic load_regs(logic invert, logic [PERIOD_W-1:0] slow_on,
                           logic [PERIOD_W-1:0] slow_off, logic [PERIOD_W-1:0] fast,
                           logic [PERIOD_W-1:0] flash, logic [PERIOD_W-1:0] pulse_off,
                           logic [PERIOD_W-1:0] pulse_on, logic [PERIOD_W-1:0] settle);
    set_reg(CFG_INVERT, PERIOD_W'(invert));
    set_reg(CFG_SLOW_ON, slow_on);
    set_reg(CFG_SLOW_OFF, slow_off);
    set_reg(CFG_FAST_HALF, fast);
    set_reg(CFG_FLASH, flash);
    set_reg(CFG_PULSE_OFF, pulse_off);
    set_reg(CFG_PULSE_ON, pulse_on);
    set_reg(CFG_SETTLE, settle);
  endtask

  task automatic load_small_regs(int top);
    load_regs(1'($urandom_range(0, 1)),
              PERIOD_W'($urandom_range(1, top)), PERIOD_W'($urandom_range(1, top)),
              PERIOD_W'($urandom_range(1, top)), PERIOD_W'($urandom_range(1, top)),
              PERIOD_W'($urandom_range(1, top)), PERIOD_W'($urandom_range(1, top)),
              PERIOD_W'($urandom_range(1, top)));
  endtask

  task automatic run_phase(int count, int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(count);
    wait_drain();
  endtask

  // Sequencer: reset once, a directed pass on the reset settings, then
  // random phases under changing register settings and traffic shapes.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pass on the reset values, no idling on either side.
    queue_cmd(FUNC_TICK, MODE_OFF, 1'b0);      // tick with the timer idle
    queue_cmd(FUNC_SET, MODE_ON, 1'b0);
    queue_cmd(FUNC_SET, MODE_SLOW, 1'b1);
    queue_cmd(FUNC_TICK, MODE_OFF, 1'b1);
    queue_cmd(FUNC_SET, MODE_FAST, 1'b0);
    queue_cmd(FUNC_SET, MODE_FLASH, 1'b0);
    queue_cmd(FUNC_SET, MODE_PULSE, 1'b1);
    queue_cmd(FUNC_SET, MODE_OFF, 1'b0);
    queue_cmd(FUNC_SET, MODE_SPARE_LO, 1'b1);  // unused mode codes mean off
    queue_cmd(FUNC_SET, MODE_SPARE_HI, 1'b0);
    queue_cmd(FUNC_OVERRIDE, MODE_ON, 1'b0);
    queue_cmd(FUNC_SET, MODE_FAST, 1'b1);      // remembered only
    queue_cmd(FUNC_REVERT, MODE_OFF, 1'b0);
    queue_cmd(FUNC_OVERRIDE, MODE_SPARE_HI, 1'b1);
    queue_cmd(FUNC_REVERT, MODE_ON, 1'b0);
    queue_cmd(FUNC_READ, MODE_OFF, 1'b1);
    queue_cmd(FUNC_READ, MODE_OFF, 1'b0);      // repeated request restarts settle
    queue_cmd(FUNC_SET, MODE_SLOW, 1'b1);      // mode event completes the read
    queue_cmd(FUNC_READ, MODE_OFF, 1'b0);
    queue_cmd(FUNC_OVERRIDE, MODE_PULSE, 1'b0);
    queue_cmd(FUNC_READ, MODE_OFF, 1'b1);
    queue_cmd(FUNC_REVERT, MODE_FLASH, 1'b1);
    for (int f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++) begin
      queue_cmd(3'(f), MODE_PULSE, 1'b1);      // unused functions change nothing
    end
    wait_drain();

    // Reset periods still in force; flash, settle and pulse-off can expire.
    run_phase(150, 0, 0);

    load_regs(1'b1, 16'd2, 16'd3, 16'd1, 16'd2, 16'd1, 16'd3, 16'd1);
    run_phase(300, 68, 0);

    load_small_regs(6);
    run_phase(300, 0, 68);

    // Extremes mixed with short periods. The receiver holds off for a long
    // stretch while the sender keeps offering, so the block backs up.
    load_regs(1'b0, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'd1, 16'd2, 16'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(200);
    hold_req++;
    wait_drain();

    // Every period zero: the timer must stay idle after each event.
    load_regs(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(150, 26, 26);

    // Two halves with a full drain between them: the sender pauses until
    // every owed result has come back.
    load_small_regs(8);
    run_phase(200, 26, 26);
    run_phase(200, 26, 26);

    load_regs(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF);
    run_phase(100, 0, 0);

    load_small_regs(4);
    run_phase(350, 0, 68);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("status_led_pattern_controller_tb passed");
    end else begin
      $display("status_led_pattern_controller_tb failed");
    end
    $finish;
  end

endmodule
